FILE: design/aesenc_pkg.sv
// ----------------------------------------------------------------------------
// aesenc_pkg
// Shared types, constants and GF(2^8) helpers for the AES-128 encrypt block.
// ----------------------------------------------------------------------------
package aesenc_pkg;

  localparam int NUM_ROUNDS = 10;
  localparam int RND_W      = 4;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 64;

  localparam logic [CFG_IDX_W-1:0] CFG_KEY_UPPER = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_LOWER = 1'b1;

  localparam logic [7:0] RCON_FIRST = 8'h01;

  typedef struct packed {
    logic [63:0] block_high;
    logic [63:0] block_low;
  } in_item_t;

  typedef struct packed {
    logic [63:0] cipher_high;
    logic [63:0] cipher_low;
  } out_item_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
    8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
    8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
    8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
    8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
    8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
    8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
    8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
    8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
    8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
    8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
    8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
    8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
    8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
    8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
    8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
    8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
    8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
    8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
    8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
    8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
    8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
    8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
    8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
    8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
    8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
    8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
    8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
    8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
    8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
    8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
    8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
  };

  function automatic logic [7:0] xtime(input logic [7:0] a);
    xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    sub_word = {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
  endfunction

endpackage

FILE: design/aesenc_key_step.sv
// ----------------------------------------------------------------------------
// aesenc_key_step
// One step of the AES-128 key schedule: round key r to round key r+1.
// ----------------------------------------------------------------------------
module aesenc_key_step
  import aesenc_pkg::*;
(
  input  logic [127:0] rk,
  input  logic [7:0]   rcon,
  output logic [127:0] rk_next
);

  logic [31:0] w0, w1, w2, w3, t;

  always_comb begin
    t  = sub_word({rk[23:0], rk[31:24]}) ^ {rcon, 24'h000000};
    w0 = rk[127:96] ^ t;
    w1 = rk[95:64] ^ w0;
    w2 = rk[63:32] ^ w1;
    w3 = rk[31:0] ^ w2;
    rk_next = {w0, w1, w2, w3};
  end

endmodule

FILE: design/aesenc_round.sv
// ----------------------------------------------------------------------------
// aesenc_round
// Shared round unit: SubBytes, ShiftRows, optional MixColumns, AddRoundKey.
// ----------------------------------------------------------------------------
module aesenc_round
  import aesenc_pkg::*;
(
  input  logic [127:0] state_in,
  input  logic [127:0] rk,
  input  logic         last,
  output logic [127:0] state_out
);

  logic [7:0] sb [16];
  logic [7:0] sr [16];
  logic [7:0] mc [16];
  logic [7:0] a0, a1, a2, a3, d0, d1, d2, d3;

  always_comb begin
    for (int i = 0; i < 16; i++) begin
      sb[i] = SBOX[state_in[127-8*i -: 8]];
    end
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        sr[4*c+r] = sb[4*((c+r)%4)+r];
      end
    end
    for (int c = 0; c < 4; c++) begin
      a0 = sr[4*c];
      a1 = sr[4*c+1];
      a2 = sr[4*c+2];
      a3 = sr[4*c+3];
      d0 = xtime(a0);
      d1 = xtime(a1);
      d2 = xtime(a2);
      d3 = xtime(a3);
      mc[4*c]   = last ? a0 : (d0 ^ d1 ^ a1 ^ a2 ^ a3);
      mc[4*c+1] = last ? a1 : (a0 ^ d1 ^ d2 ^ a2 ^ a3);
      mc[4*c+2] = last ? a2 : (a0 ^ a1 ^ d2 ^ d3 ^ a3);
      mc[4*c+3] = last ? a3 : (d0 ^ a0 ^ a1 ^ a2 ^ d3);
    end
    for (int i = 0; i < 16; i++) begin
      state_out[127-8*i -: 8] = mc[i] ^ rk[127-8*i -: 8];
    end
  end

endmodule

FILE: design/aes128_block_encrypt_top.sv
// ----------------------------------------------------------------------------
// aes128_block_encrypt_top
// AES-128 block encryption with one shared round unit and on-the-fly keys.
// ----------------------------------------------------------------------------
//  Channel | Signals                          | Direction
//  --------+----------------------------------+----------
//  in      | in_valid, in_stall, in_data      | plaintext transaction into block
//  out     | out_valid, out_stall, out_data   | ciphertext transaction out of block
//  cfg     | cfg_we, cfg_index, cfg_data      | key register writes
//
//  The accept cycle does the initial key addition, then each round runs the
//  shared round unit once, with the key schedule step producing the next
//  round key in the same cycle.
//  in_stall stays high while a transaction is in the rounds.
//  Reset clears the key to zero and drops any transaction in flight.
//  A result waits in the output register; the final round holds while it is
//  still occupied and stalled.
// ----------------------------------------------------------------------------
module aes128_block_encrypt_top
  import aesenc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  typedef enum logic {IDLE, RUN} fsm_t;

  fsm_t             st;
  logic [63:0]      key_upper, key_lower;
  logic [127:0]     state, rk, rk_next, round_out;
  logic [7:0]       rcon;
  logic [RND_W-1:0] rnd;
  logic             last;
  logic             done;

  assign last     = (rnd == RND_W'(NUM_ROUNDS));
  assign in_stall = (st != IDLE);
  // final round completes when the output register is free or being taken
  assign done     = (st == RUN) && last && (!out_valid || !out_stall);

  aesenc_key_step u_key (
    .rk      (rk),
    .rcon    (rcon),
    .rk_next (rk_next)
  );

  aesenc_round u_round (
    .state_in  (state),
    .rk        (rk_next),
    .last      (last),
    .state_out (round_out)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= IDLE;
      out_valid <= 1'b0;
      key_upper <= '0;
      key_lower <= '0;
      rnd       <= '0;
    end else begin
      // key writes land at once; a transaction in flight keeps its latched key
      if (cfg_we) begin
        case (cfg_index)
          CFG_KEY_UPPER: key_upper <= cfg_data;
          CFG_KEY_LOWER: key_lower <= cfg_data;
          default: ;
        endcase
      end
      // load a finished result, else drop the output once taken
      if (done) begin
        out_data  <= {round_out[127:64], round_out[63:0]};
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (st)
        IDLE: begin
          if (in_valid) begin
            state <= {in_data.block_high, in_data.block_low} ^ {key_upper, key_lower};
            rk    <= {key_upper, key_lower};
            rcon  <= RCON_FIRST;
            rnd   <= RND_W'(1);
            st    <= RUN;
          end
        end
        RUN: begin
          if (!last) begin
            // advance one round
            state <= round_out;
            rk    <= rk_next;
            rcon  <= xtime(rcon);
            rnd   <= rnd + RND_W'(1);
          end else if (done) begin
            st <= IDLE;
          end
        end
        default: st <= IDLE;
      endcase
    end
  end

  // finishing a transaction always fills the output register
  a_finish_loads: assert property (@(posedge clk) disable iff (rst)
    $fell(in_stall) && !$past(rst) |-> out_valid)
    else $error("finished transaction did not load output");

  // an accepted transaction starts at the first round with the first rcon
  a_start: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall && rnd == RND_W'(1) && rcon == RCON_FIRST)
    else $error("transaction did not start at round one");

  // round counter stays within range while running
  a_rnd_range: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> rnd != '0 && rnd <= RND_W'(NUM_ROUNDS))
    else $error("round counter out of range");

endmodule

FILE: bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the AES-128 encrypt block. Computes every expected
// ciphertext in the bench itself and compares it field by field with what the
// block returns, under random gaps and stalls on both channels.
// ----------------------------------------------------------------------------
class cipher_scoreboard;
  aesenc_pkg::out_item_t pending_cipher[$];
  logic [63:0] key_hi;
  logic [63:0] key_lo;
  logic [31:0] sched[44];
  int mismatches;

  function new();
    key_hi = '0;
    key_lo = '0;
    mismatches = 0;
    expand();
  endfunction

  function logic [7:0] gmul2(logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function logic [7:0] sbox_of(logic [7:0] x);
    logic [7:0] inv;
    logic [7:0] base;
    logic [7:0] acc;
    logic [7:0] a;
    logic [7:0] b;
    int e;
    inv = 8'h01;
    base = x;
    for (e = 0; e < 8; e++) begin
      // exponent 254 = 0b11111110
      if (e != 0) begin
        acc = 0; a = inv; b = base;
        repeat (8) begin
          if (b[0]) acc ^= a;
          a = gmul2(a);
          b = b >> 1;
        end
        inv = acc;
      end
      acc = 0; a = base; b = base;
      repeat (8) begin
        if (b[0]) acc ^= a;
        a = gmul2(a);
        b = b >> 1;
      end
      base = acc;
    end
    if (x == 0) inv = 0;
    return inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^ {inv[4:0], inv[7:5]}
           ^ {inv[3:0], inv[7:4]} ^ 8'h63;
  endfunction

  function void expand();
    logic [31:0] t;
    logic [7:0] rc;
    int i;
    rc = 8'h01;
    sched[0] = key_hi[63:32]; sched[1] = key_hi[31:0];
    sched[2] = key_lo[63:32]; sched[3] = key_lo[31:0];
    for (i = 4; i < 44; i++) begin
      t = sched[i-1];
      if (i % 4 == 0) begin
        t = {t[23:0], t[31:24]};
        t = {sbox_of(t[31:24]) ^ rc, sbox_of(t[23:16]), sbox_of(t[15:8]), sbox_of(t[7:0])};
        rc = gmul2(rc);
      end
      sched[i] = sched[i-4] ^ t;
    end
  endfunction

  // Apply a key register write; unknown indexes leave the key alone.
  function void write_key(int idx, logic [63:0] val);
    if (idx == 0) key_hi = val;
    else if (idx == 1) key_lo = val;
    else return;
    expand();
  endfunction

  function aesenc_pkg::out_item_t encrypt(aesenc_pkg::in_item_t blk);
    logic [7:0] st[16];
    logic [7:0] tmp[16];
    logic [7:0] a0, a1, a2, a3;
    logic [127:0] flat;
    int i, c, r, rnd;
    aesenc_pkg::out_item_t res;
    flat = {blk.block_high, blk.block_low};
    for (i = 0; i < 16; i++) st[i] = flat[127-8*i -: 8];
    for (rnd = 0; rnd <= 10; rnd++) begin
      if (rnd > 0) begin
        for (i = 0; i < 16; i++) st[i] = sbox_of(st[i]);
        for (c = 0; c < 4; c++)
          for (r = 0; r < 4; r++) tmp[4*c+r] = st[4*((c+r)%4)+r];
        st = tmp;
        if (rnd < 10) begin
          for (c = 0; c < 4; c++) begin
            a0 = st[4*c]; a1 = st[4*c+1]; a2 = st[4*c+2]; a3 = st[4*c+3];
            st[4*c]   = gmul2(a0) ^ gmul2(a1) ^ a1 ^ a2 ^ a3;
            st[4*c+1] = a0 ^ gmul2(a1) ^ gmul2(a2) ^ a2 ^ a3;
            st[4*c+2] = a0 ^ a1 ^ gmul2(a2) ^ gmul2(a3) ^ a3;
            st[4*c+3] = gmul2(a0) ^ a0 ^ a1 ^ a2 ^ gmul2(a3);
          end
        end
      end
      for (i = 0; i < 16; i++) st[i] ^= sched[4*rnd + i/4][31-8*(i%4) -: 8];
    end
    for (i = 0; i < 16; i++) flat[127-8*i -: 8] = st[i];
    res.cipher_high = flat[127:64];
    res.cipher_low = flat[63:0];
    return res;
  endfunction

  function void note_plaintext(aesenc_pkg::in_item_t blk);
    pending_cipher.push_back(encrypt(blk));
  endfunction

  // Returns a description of the mismatch, empty when the result is good.
  function string check_cipher(aesenc_pkg::out_item_t got);
    aesenc_pkg::out_item_t want;
    if (pending_cipher.size() == 0) return "ciphertext with none pending";
    want = pending_cipher.pop_front();
    if (got.cipher_high !== want.cipher_high)
      return $sformatf("cipher_high got %h want %h", got.cipher_high, want.cipher_high);
    if (got.cipher_low !== want.cipher_low)
      return $sformatf("cipher_low got %h want %h", got.cipher_low, want.cipher_low);
    return "";
  endfunction
endclass

module tb;
  import aesenc_pkg::*;

  localparam int IDLE_LIMIT = 20000;
  localparam int N_RANDOM   = 1250;

  logic                  clk;
  logic                  rst;
  logic                  in_valid;
  logic                  in_stall;
  in_item_t              in_data;
  logic                  out_valid;
  logic                  out_stall;
  out_item_t             out_data;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  cipher_scoreboard sb;
  int  fail_count;
  int  idle_cycles;
  bit  hold_off_req;

  aes128_block_encrypt_top dut (
    .clk, .rst, .in_valid, .in_stall, .in_data, .out_valid, .out_stall,
    .out_data, .cfg_we, .cfg_index, .cfg_data
  );

  always begin
    clk = 1'b0; #6;
    clk = 1'b1; #6;
  end

  task automatic report(string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    fail_count++;
  endtask

  // Gap length: mostly short, now and then long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Offer one plaintext and hold it until the block takes it; then drop valid
  // for one cycle.
  task automatic send_block(logic [63:0] hi, logic [63:0] lo);
    in_valid <= 1'b1;
    in_data <= '{block_high: hi, block_low: lo};
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    in_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic send_gapped(logic [63:0] hi, logic [63:0] lo);
    int g;
    g = pick_gap();
    repeat (g) @(negedge clk);
    send_block(hi, lo);
  endtask

  // Drain: wait for every expected ciphertext, then let the round unit settle.
  task automatic drain();
    while (sb.pending_cipher.size() != 0) @(negedge clk);
    repeat (15) @(negedge clk);
  endtask

  task automatic write_key(int idx, logic [63:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx[CFG_IDX_W-1:0];
    cfg_data <= val;
    @(posedge clk);
    sb.write_key(idx, val);
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // Note accepted plaintext transactions in the scoreboard.
  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) sb.note_plaintext(in_data);
  end

  // Check every accepted ciphertext transaction.
  always @(posedge clk) begin
    string msg;
    if (!rst && out_valid && !out_stall) begin
      msg = sb.check_cipher(out_data);
      if (msg != "") report(msg);
    end
  end

  // Receiver stall: random, with one long hold-off on request.
  initial begin
    int g;
    out_stall = 1'b1;
    @(negedge clk);
    forever begin
      if (hold_off_req) begin
        out_stall <= 1'b1;
        repeat (300) @(negedge clk);
        hold_off_req = 1'b0;
      end
      g = pick_gap();
      out_stall <= (g != 0);
      repeat (g != 0 ? g : $urandom_range(1, 8)) @(negedge clk);
    end
  end

  // Watchdog: too long with no transaction on either channel.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    int i, k;
    logic [63:0] hi, lo;
    sb = new();
    fail_count = 0;
    hold_off_req = 0;
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_index = CFG_KEY_UPPER;
    cfg_data = '0;
    repeat (10) @(negedge clk);
    rst <= 1'b0;

    // Directed: reset key (all zero), extreme plaintexts.
    send_block('0, '0);
    send_block('1, '1);
    send_block(64'h0011223344556677, 64'h8899aabbccddeeff);
    drain();
    // Standard key; then a partial update touching only the lower half.
    write_key(CFG_KEY_UPPER, 64'h0001020304050607);
    write_key(CFG_KEY_LOWER, 64'h08090a0b0c0d0e0f);
    send_block(64'h0011223344556677, 64'h8899aabbccddeeff);
    send_block('1, '0);
    drain();
    write_key(CFG_KEY_LOWER, '1);
    send_block('0, '1);
    send_block(64'h8000000000000000, 64'h0000000000000001);
    drain();
    write_key(CFG_KEY_UPPER, '1);
    send_block('0, '0);
    send_block('1, '1);
    drain();

    // Long receiver hold-off while the sender keeps offering.
    hold_off_req = 1'b1;
    for (i = 0; i < 8; i++) send_block(rand64(), rand64());
    // Sender pauses until everything has come back.
    drain();

    // Random phases with a fresh key each time, extremes included.
    for (k = 0; k < 10; k++) begin
      case (k)
        0: begin hi = '0; lo = '0; end
        1: begin hi = '1; lo = '1; end
        default: begin hi = rand64(); lo = rand64(); end
      endcase
      write_key(CFG_KEY_UPPER, hi);
      write_key(CFG_KEY_LOWER, lo);
      for (i = 0; i < N_RANDOM / 10; i++) begin
        case ($urandom_range(0, 9))
          0: send_gapped('0, rand64());
          1: send_gapped(rand64(), '1);
          default: send_gapped(rand64(), rand64());
        endcase
      end
      drain();
    end

    if (fail_count == 0 && sb.pending_cipher.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      if (sb.pending_cipher.size() != 0) report("ciphertexts left pending");
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
